### sv/eecs_pkg.sv
// shared types and codes for the spi eeprom command sequencer
// no dependencies; used by every module of the block
package eecs_pkg;

  localparam int unsigned PAGE_BYTES_DEF = 128;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam logic [2:0] REQ_READ   = 3'd0;
  localparam logic [2:0] REQ_WRITE  = 3'd1;
  localparam logic [2:0] REQ_ERASE  = 3'd2;
  localparam logic [2:0] REQ_NEXT   = 3'd3;
  localparam logic [2:0] REQ_FINISH = 3'd4;
  localparam logic [2:0] REQ_REPLY  = 3'd5;

  localparam logic [1:0] ACT_SEL     = 2'd0;
  localparam logic [1:0] ACT_XFER    = 2'd1;
  localparam logic [1:0] ACT_REL     = 2'd2;
  localparam logic [1:0] ACT_DELIVER = 2'd3;

  localparam logic [7:0] OP_WREN  = 8'h06;
  localparam logic [7:0] OP_RDSR  = 8'h05;
  localparam logic [7:0] OP_WRITE = 8'h02;
  localparam logic [7:0] OP_READ  = 8'h03;
  localparam logic [7:0] OP_CE    = 8'hC7;
  localparam logic [7:0] WIP_MASK = 8'h01;
  localparam logic [7:0] DUMMY    = 8'h00;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] start_address;
    logic [7:0]  byte_value;
  } in_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] out_byte;
    logic       needs_reply;
    logic       last;
  } out_t;

  typedef enum logic [2:0] {
    JOB_POLL,
    JOB_REL_POLL,
    JOB_READ,
    JOB_WRITE,
    JOB_ERASE,
    JOB_XFER,
    JOB_DELIVER,
    JOB_REL
  } job_kind_t;

  // flag: write job appends data byte; xfer job expects a reply
  typedef struct packed {
    job_kind_t   kind;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        flag;
  } job_t;

endpackage

### sv/spi_eeprom_command_sequencer_core.sv
// spi eeprom command sequencer, 25xx protocol: requests in, spi actions out
// instantiates eecs_front, eecs_queue and eecs_back; depends on eecs_pkg
//
// in channel (in_valid/in_ready/in_data) takes requests: begin read, begin
// write, chip erase, next byte, finish and reply. out channel
// (out_valid/out_ready/out_data) gives spi actions: select, byte transfer,
// release, read byte delivered; last marks the final action of a request.
// a request is classified in the cycle it is taken and queued as one job;
// the job is queued, then its first action is registered on out. while out
// is not stalled, actions leave one per cycle; a request expands into 1 to
// 8 actions (write start with a held byte is 8, a status poll 4). the
// two-entry job queue lets requests keep coming while earlier actions
// drain; in_ready drops only when full. requests that cause no action queue
// no job. a stalled out holds its action and the queue fills behind it.
// reset (rst_n low, synchronous) returns to idle with no pending command,
// address zero and an empty queue. PAGE_BYTES must be a power of two.
module spi_eeprom_command_sequencer_core #(
  parameter int unsigned PAGE_BYTES = eecs_pkg::PAGE_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  eecs_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output eecs_pkg::out_t out_data
);

  logic           in_fire;
  logic           push;
  eecs_pkg::job_t push_job;
  logic           full;
  logic           pop;
  logic           head_valid;
  eecs_pkg::job_t head;

  assign in_ready = !full;
  assign in_fire  = in_valid && in_ready;

  eecs_front #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_item (in_data),
    .push    (push),
    .job     (push_job)
  );

  eecs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  eecs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

### sv/eecs_front.sv
// front end: accepts requests, tracks protocol state, emits at most one job per item
// depends on eecs_pkg
module eecs_front #(
  parameter int unsigned PAGE_BYTES = eecs_pkg::PAGE_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  eecs_pkg::in_t in_item,
  output logic          push,
  output eecs_pkg::job_t job
);

  localparam logic [15:0] PAGE_MASK = 16'(PAGE_BYTES - 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_POLL,
    PH_READ,
    PH_WRITE
  } phase_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_READ,
    CMD_WRITE,
    CMD_ERASE
  } cmd_t;

  phase_t      phase_r, phase_nxt;
  cmd_t        cmd_r, cmd_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        first_r, first_nxt;

  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    addr_nxt  = addr_r;
    held_nxt  = held_r;
    first_nxt = first_r;
    push      = 1'b0;
    job.kind  = eecs_pkg::JOB_POLL;
    job.addr  = addr_r;
    job.data  = in_item.byte_value;
    job.flag  = 1'b0;
    if (in_fire) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (in_item.req_type == eecs_pkg::REQ_READ ||
              in_item.req_type == eecs_pkg::REQ_WRITE ||
              in_item.req_type == eecs_pkg::REQ_ERASE) begin
            unique case (in_item.req_type)
              eecs_pkg::REQ_READ:  cmd_nxt = CMD_READ;
              eecs_pkg::REQ_WRITE: cmd_nxt = CMD_WRITE;
              default:             cmd_nxt = CMD_ERASE;
            endcase
            addr_nxt  = (in_item.req_type == eecs_pkg::REQ_ERASE) ? 16'd0
                                                                  : in_item.start_address;
            first_nxt = 1'b1;
            phase_nxt = PH_POLL;
            push      = 1'b1;
            job.kind  = eecs_pkg::JOB_POLL;
          end
        end
        PH_POLL: begin
          if (in_item.req_type == eecs_pkg::REQ_REPLY) begin
            if ((in_item.byte_value & eecs_pkg::WIP_MASK) != 8'd0) begin
              push     = 1'b1;
              job.kind = eecs_pkg::JOB_POLL;
            end else begin
              unique case (cmd_r)
                CMD_READ: begin
                  push      = 1'b1;
                  job.kind  = eecs_pkg::JOB_READ;
                  phase_nxt = PH_READ;
                end
                CMD_WRITE: begin
                  push      = 1'b1;
                  job.kind  = eecs_pkg::JOB_WRITE;
                  job.data  = held_r;
                  job.flag  = !first_r;
                  if (!first_r) begin
                    addr_nxt = addr_r + 16'd1;
                  end
                  phase_nxt = PH_WRITE;
                end
                CMD_ERASE: begin
                  push      = 1'b1;
                  job.kind  = eecs_pkg::JOB_ERASE;
                  phase_nxt = PH_IDLE;
                  cmd_nxt   = CMD_NONE;
                end
                default: phase_nxt = PH_IDLE;
              endcase
            end
          end
        end
        PH_READ: begin
          unique case (in_item.req_type)
            eecs_pkg::REQ_NEXT: begin
              push     = 1'b1;
              job.kind = eecs_pkg::JOB_XFER;
              job.data = eecs_pkg::DUMMY;
              job.flag = 1'b1;
            end
            eecs_pkg::REQ_REPLY: begin
              push     = 1'b1;
              job.kind = eecs_pkg::JOB_DELIVER;
            end
            eecs_pkg::REQ_FINISH: begin
              push      = 1'b1;
              job.kind  = eecs_pkg::JOB_REL;
              phase_nxt = PH_IDLE;
              cmd_nxt   = CMD_NONE;
            end
            default: ;
          endcase
        end
        default: begin
          unique case (in_item.req_type)
            eecs_pkg::REQ_NEXT: begin
              push = 1'b1;
              if (!first_r && (addr_r & PAGE_MASK) == 16'd0) begin
                job.kind  = eecs_pkg::JOB_REL_POLL;
                held_nxt  = in_item.byte_value;
                phase_nxt = PH_POLL;
              end else begin
                job.kind  = eecs_pkg::JOB_XFER;
                first_nxt = 1'b0;
                addr_nxt  = addr_r + 16'd1;
              end
            end
            eecs_pkg::REQ_FINISH: begin
              push      = 1'b1;
              job.kind  = eecs_pkg::JOB_REL;
              phase_nxt = PH_IDLE;
              cmd_nxt   = CMD_NONE;
            end
            default: ;
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cmd_r   <= CMD_NONE;
      addr_r  <= 16'd0;
      held_r  <= 8'd0;
      first_r <= 1'b1;
    end else begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      addr_r  <= addr_nxt;
      held_r  <= held_nxt;
      first_r <= first_nxt;
    end
  end

  // a poll in flight always has a command to resume
  a_poll_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_POLL |-> cmd_r != CMD_NONE)
    else $error("poll phase without pending command");

endmodule

### sv/eecs_queue.sv
// short job queue between front end and action sequencer
// depends on eecs_pkg
module eecs_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  eecs_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output eecs_pkg::job_t head
);

  localparam int unsigned PW = $clog2(eecs_pkg::QUEUE_DEPTH);

  eecs_pkg::job_t          mem_r [eecs_pkg::QUEUE_DEPTH];
  logic [PW-1:0]           wr_ptr_r, rd_ptr_r;
  logic [PW:0]             count_r;

  assign full       = count_r == (PW + 1)'(eecs_pkg::QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(eecs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(eecs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (PW + 1)'(push) - (PW + 1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !head_valid))
    else $error("job queue underflow");

endmodule

### sv/eecs_back.sv
// action sequencer: expands queued jobs into spi actions, one per cycle while out is not stalled
// depends on eecs_pkg
module eecs_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  eecs_pkg::job_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output eecs_pkg::out_t out_data
);

  logic [2:0]     idx_r, idx_nxt;
  logic           out_valid_r, out_valid_nxt;
  eecs_pkg::out_t out_data_r, out_data_nxt;
  eecs_pkg::out_t step;
  logic           advance;

  function automatic eecs_pkg::out_t expand(eecs_pkg::job_t j, logic [2:0] i);
    eecs_pkg::out_t o;
    logic [2:0]     p;
    o = '0;
    p = i;
    unique case (j.kind) inside
      eecs_pkg::JOB_POLL, eecs_pkg::JOB_REL_POLL: begin
        if (j.kind == eecs_pkg::JOB_REL_POLL) begin
          p = i - 3'd1;
        end
        if (j.kind == eecs_pkg::JOB_REL_POLL && i == 3'd0) begin
          o.action = eecs_pkg::ACT_REL;
        end else begin
          unique case (p)
            3'd0: o.action = eecs_pkg::ACT_SEL;
            3'd1: begin
              o.action   = eecs_pkg::ACT_XFER;
              o.out_byte = eecs_pkg::OP_RDSR;
            end
            3'd2: begin
              o.action      = eecs_pkg::ACT_XFER;
              o.out_byte    = eecs_pkg::DUMMY;
              o.needs_reply = 1'b1;
            end
            default: begin
              o.action = eecs_pkg::ACT_REL;
              o.last   = 1'b1;
            end
          endcase
        end
      end
      eecs_pkg::JOB_READ: begin
        unique case (i)
          3'd0: o.action = eecs_pkg::ACT_SEL;
          3'd1: begin
            o.action   = eecs_pkg::ACT_XFER;
            o.out_byte = eecs_pkg::OP_READ;
          end
          3'd2: begin
            o.action   = eecs_pkg::ACT_XFER;
            o.out_byte = j.addr[15:8];
          end
          default: begin
            o.action   = eecs_pkg::ACT_XFER;
            o.out_byte = j.addr[7:0];
            o.last     = 1'b1;
          end
        endcase
      end
      eecs_pkg::JOB_WRITE: begin
        unique case (i)
          3'd0, 3'd3: o.action = eecs_pkg::ACT_SEL;
          3'd1: begin
            o.action   = eecs_pkg::ACT_XFER;
            o.out_byte = eecs_pkg::OP_WREN;
          end
          3'd2: o.action = eecs_pkg::ACT_REL;
          3'd4: begin
            o.action   = eecs_pkg::ACT_XFER;
            o.out_byte = eecs_pkg::OP_WRITE;
          end
          3'd5: begin
            o.action   = eecs_pkg::ACT_XFER;
            o.out_byte = j.addr[15:8];
          end
          3'd6: begin
            o.action   = eecs_pkg::ACT_XFER;
            o.out_byte = j.addr[7:0];
            o.last     = !j.flag;
          end
          default: begin
            o.action   = eecs_pkg::ACT_XFER;
            o.out_byte = j.data;
            o.last     = 1'b1;
          end
        endcase
      end
      eecs_pkg::JOB_ERASE: begin
        unique case (i)
          3'd0, 3'd3: o.action = eecs_pkg::ACT_SEL;
          3'd1: begin
            o.action   = eecs_pkg::ACT_XFER;
            o.out_byte = eecs_pkg::OP_WREN;
          end
          3'd2: o.action = eecs_pkg::ACT_REL;
          3'd4: begin
            o.action   = eecs_pkg::ACT_XFER;
            o.out_byte = eecs_pkg::OP_CE;
          end
          default: begin
            o.action = eecs_pkg::ACT_REL;
            o.last   = 1'b1;
          end
        endcase
      end
      eecs_pkg::JOB_XFER: begin
        o.action      = eecs_pkg::ACT_XFER;
        o.out_byte    = j.data;
        o.needs_reply = j.flag;
        o.last        = 1'b1;
      end
      eecs_pkg::JOB_DELIVER: begin
        o.action   = eecs_pkg::ACT_DELIVER;
        o.out_byte = j.data;
        o.last     = 1'b1;
      end
      default: begin
        o.action = eecs_pkg::ACT_REL;
        o.last   = 1'b1;
      end
    endcase
    return o;
  endfunction

  assign step    = expand(head, idx_r);
  assign advance = head_valid && (!out_valid_r || out_ready);
  assign pop     = advance && step.last;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = step;
      idx_nxt       = step.last ? 3'd0 : idx_r + 3'd1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a job part-way through expansion stays at the queue head
  a_mid_job_head: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != 3'd0 |-> head_valid)
    else $error("job expansion lost its queue entry");

endmodule

### dv/eecs_action_checker.sv
// action checker for the spi eeprom command sequencer: watches both channels,
// predicts the spi actions of every request and compares them in order
// depends on eecs_pkg
module eecs_action_checker #(
  parameter int unsigned PAGE_BYTES = eecs_pkg::PAGE_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  eecs_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  eecs_pkg::out_t out_data,
  output int unsigned    fail_count,
  output int unsigned    expected_left,
  output int unsigned    actions_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {SEQ_IDLE, SEQ_POLL, SEQ_READ, SEQ_WRITE} seq_phase_t;
  typedef enum logic [1:0] {CMD_NONE, CMD_READ, CMD_WRITE, CMD_ERASE} cmd_t;

  seq_phase_t     phase_q;
  cmd_t           cmd_q;
  logic [15:0]    addr_q;
  logic [7:0]     held_q;
  logic           first_q;
  eecs_pkg::out_t expected_actions[$];
  eecs_pkg::out_t step_actions[$];

  task automatic report_mismatch(string msg);
    fail_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic void add_action(logic [1:0] act, logic [7:0] b, logic nr);
    eecs_pkg::out_t a;
    a.action      = act;
    a.out_byte    = b;
    a.needs_reply = nr;
    a.last        = 1'b0;
    step_actions.push_back(a);
  endfunction

  function automatic void add_status_poll();
    add_action(eecs_pkg::ACT_SEL, 8'h00, 1'b0);
    add_action(eecs_pkg::ACT_XFER, eecs_pkg::OP_RDSR, 1'b0);
    add_action(eecs_pkg::ACT_XFER, eecs_pkg::DUMMY, 1'b1);
    add_action(eecs_pkg::ACT_REL, 8'h00, 1'b0);
  endfunction

  function automatic void begin_command(cmd_t c, logic [15:0] a);
    cmd_q   = c;
    addr_q  = a;
    first_q = 1'b1;
    phase_q = SEQ_POLL;
    add_status_poll();
  endfunction

  function automatic void predict_spi_actions(eecs_pkg::in_t r);
    eecs_pkg::out_t tail;
    step_actions.delete();
    case (phase_q)
      SEQ_IDLE: begin
        if (r.req_type == eecs_pkg::REQ_READ) begin_command(CMD_READ, r.start_address);
        else if (r.req_type == eecs_pkg::REQ_WRITE) begin_command(CMD_WRITE, r.start_address);
        else if (r.req_type == eecs_pkg::REQ_ERASE) begin_command(CMD_ERASE, 16'h0000);
      end
      SEQ_POLL: begin
        if (r.req_type == eecs_pkg::REQ_REPLY) begin
          if ((r.byte_value & eecs_pkg::WIP_MASK) != 8'h00) begin
            add_status_poll();
          end else begin
            case (cmd_q)
              CMD_READ: begin
                add_action(eecs_pkg::ACT_SEL, 8'h00, 1'b0);
                add_action(eecs_pkg::ACT_XFER, eecs_pkg::OP_READ, 1'b0);
                add_action(eecs_pkg::ACT_XFER, addr_q[15:8], 1'b0);
                add_action(eecs_pkg::ACT_XFER, addr_q[7:0], 1'b0);
                phase_q = SEQ_READ;
              end
              CMD_WRITE: begin
                add_action(eecs_pkg::ACT_SEL, 8'h00, 1'b0);
                add_action(eecs_pkg::ACT_XFER, eecs_pkg::OP_WREN, 1'b0);
                add_action(eecs_pkg::ACT_REL, 8'h00, 1'b0);
                add_action(eecs_pkg::ACT_SEL, 8'h00, 1'b0);
                add_action(eecs_pkg::ACT_XFER, eecs_pkg::OP_WRITE, 1'b0);
                add_action(eecs_pkg::ACT_XFER, addr_q[15:8], 1'b0);
                add_action(eecs_pkg::ACT_XFER, addr_q[7:0], 1'b0);
                // restart after a page boundary carries the held data byte
                if (!first_q) begin
                  add_action(eecs_pkg::ACT_XFER, held_q, 1'b0);
                  addr_q = addr_q + 16'd1;
                end
                phase_q = SEQ_WRITE;
              end
              CMD_ERASE: begin
                add_action(eecs_pkg::ACT_SEL, 8'h00, 1'b0);
                add_action(eecs_pkg::ACT_XFER, eecs_pkg::OP_WREN, 1'b0);
                add_action(eecs_pkg::ACT_REL, 8'h00, 1'b0);
                add_action(eecs_pkg::ACT_SEL, 8'h00, 1'b0);
                add_action(eecs_pkg::ACT_XFER, eecs_pkg::OP_CE, 1'b0);
                add_action(eecs_pkg::ACT_REL, 8'h00, 1'b0);
                phase_q = SEQ_IDLE;
                cmd_q   = CMD_NONE;
              end
              default: phase_q = SEQ_IDLE;
            endcase
          end
        end
      end
      SEQ_READ: begin
        if (r.req_type == eecs_pkg::REQ_NEXT) begin
          add_action(eecs_pkg::ACT_XFER, eecs_pkg::DUMMY, 1'b1);
        end else if (r.req_type == eecs_pkg::REQ_REPLY) begin
          add_action(eecs_pkg::ACT_DELIVER, r.byte_value, 1'b0);
        end else if (r.req_type == eecs_pkg::REQ_FINISH) begin
          add_action(eecs_pkg::ACT_REL, 8'h00, 1'b0);
          phase_q = SEQ_IDLE;
          cmd_q   = CMD_NONE;
        end
      end
      SEQ_WRITE: begin
        if (r.req_type == eecs_pkg::REQ_NEXT) begin
          if (!first_q && (addr_q % PAGE_BYTES) == 0) begin
            add_action(eecs_pkg::ACT_REL, 8'h00, 1'b0);
            add_status_poll();
            held_q  = r.byte_value;
            phase_q = SEQ_POLL;
          end else begin
            add_action(eecs_pkg::ACT_XFER, r.byte_value, 1'b0);
            first_q = 1'b0;
            addr_q  = addr_q + 16'd1;
          end
        end else if (r.req_type == eecs_pkg::REQ_FINISH) begin
          add_action(eecs_pkg::ACT_REL, 8'h00, 1'b0);
          phase_q = SEQ_IDLE;
          cmd_q   = CMD_NONE;
        end
      end
      default: phase_q = SEQ_IDLE;
    endcase
    if (step_actions.size() > 0) begin
      tail      = step_actions.pop_back();
      tail.last = 1'b1;
      step_actions.push_back(tail);
    end
    foreach (step_actions[i]) expected_actions.push_back(step_actions[i]);
  endfunction

  always @(posedge clk) begin
    eecs_pkg::out_t got;
    eecs_pkg::out_t want;
    if (!rst_n) begin
      phase_q         = SEQ_IDLE;
      cmd_q           = CMD_NONE;
      addr_q          = 16'h0000;
      held_q          = 8'h00;
      first_q         = 1'b1;
      fail_count      = 0;
      actions_checked = 0;
      expected_actions.delete();
    end else begin
      // outputs first: an action taken in this cycle belongs to an earlier request
      if (out_valid && out_ready) begin
        got = out_data;
        actions_checked++;
        if (expected_actions.size() == 0) begin
          report_mismatch($sformatf("unexpected action %0d byte %02h reply %0b last %0b",
                                    got.action, got.out_byte, got.needs_reply, got.last));
        end else begin
          want = expected_actions.pop_front();
          if (got.action !== want.action || got.out_byte !== want.out_byte ||
              got.needs_reply !== want.needs_reply || got.last !== want.last) begin
            report_mismatch($sformatf(
              "got action %0d byte %02h reply %0b last %0b, want %0d %02h %0b %0b",
              got.action, got.out_byte, got.needs_reply, got.last,
              want.action, want.out_byte, want.needs_reply, want.last));
          end
        end
      end
      if (in_valid && in_ready) predict_spi_actions(in_data);
    end
    expected_left = expected_actions.size();
  end

endmodule

### dv/tb.sv
// top of the spi eeprom command sequencer testbench: clock, reset, request
// stimulus, random output stalls and the verdict
// depends on eecs_pkg, spi_eeprom_command_sequencer_core and eecs_action_checker
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]  REQ_SPARE6   = 3'd6;
  localparam logic [2:0]  REQ_SPARE7   = 3'd7;
  localparam int unsigned RANDOM_ITEMS = 130;
  localparam int unsigned QUIET_ITEMS  = 40;

  bit             clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  eecs_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready = 1'b0;
  eecs_pkg::out_t out_data;
  bit             quiet;
  int unsigned    fail_count;
  int unsigned    expected_left;
  int unsigned    actions_checked;
  int unsigned    requests_sent;
  int unsigned    noise_sent;
  int unsigned    page_restarts;
  int unsigned    useful_goal;

  spi_eeprom_command_sequencer_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  eecs_action_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .expected_left  (expected_left),
    .actions_checked(actions_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= quiet || ($urandom_range(99) >= 33);
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_req(logic [2:0] t, logic [15:0] a, logic [7:0] v);
    eecs_pkg::in_t r;
    while (!quiet && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    r.req_type      = t;
    r.start_address = a;
    r.byte_value    = v;
    in_data  <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    requests_sent++;
  endtask

  task automatic drain_actions();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_left != 0) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_address();
    case ($urandom_range(3))
      0: return 16'($urandom_range(0, 65535 / eecs_pkg::PAGE_BYTES_DEF)
                    * eecs_pkg::PAGE_BYTES_DEF - $urandom_range(1, 8));
      1: return 16'hFFFF - 16'($urandom_range(0, 6));
      default: return 16'($urandom);
    endcase
  endfunction

  // busy status up to two times, then ready
  task automatic answer_status();
    int busy;
    busy = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (busy)
      send_req(eecs_pkg::REQ_REPLY, 16'($urandom), 8'($urandom) | eecs_pkg::WIP_MASK);
    send_req(eecs_pkg::REQ_REPLY, 16'($urandom), 8'($urandom) & ~eecs_pkg::WIP_MASK);
  endtask

  task automatic write_burst();
    logic [15:0] a;
    bit          first;
    int          n;
    a     = pick_address();
    first = 1'b1;
    n     = ($urandom_range(9) == 0) ? $urandom_range(100, 140) : $urandom_range(1, 20);
    send_req(eecs_pkg::REQ_WRITE, a, 8'($urandom));
    answer_status();
    repeat (n) begin
      send_req(eecs_pkg::REQ_NEXT, 16'($urandom), 8'($urandom));
      if (!first && (a % eecs_pkg::PAGE_BYTES_DEF) == 0) begin
        answer_status();
        page_restarts++;
      end
      first = 1'b0;
      a     = a + 16'd1;
    end
    send_req(eecs_pkg::REQ_FINISH, 16'($urandom), 8'($urandom));
  endtask

  task automatic read_burst();
    int n;
    n = $urandom_range(1, 12);
    send_req(eecs_pkg::REQ_READ, pick_address(), 8'($urandom));
    answer_status();
    repeat (n) begin
      send_req(eecs_pkg::REQ_NEXT, 16'($urandom), 8'($urandom));
      send_req(eecs_pkg::REQ_REPLY, 16'($urandom), 8'($urandom));
      if ($urandom_range(4) == 0) send_req(eecs_pkg::REQ_REPLY, 16'($urandom), 8'($urandom));
    end
    send_req(eecs_pkg::REQ_FINISH, 16'($urandom), 8'($urandom));
  endtask

  // random codes in any state, then a ready status and finish bring it back to idle
  task automatic noise_burst();
    int unsigned before_cnt;
    before_cnt = requests_sent;
    repeat ($urandom_range(3, 6))
      send_req(3'($urandom_range(7)), 16'($urandom), 8'($urandom));
    send_req(eecs_pkg::REQ_REPLY, 16'($urandom), 8'h00);
    send_req(eecs_pkg::REQ_FINISH, 16'($urandom), 8'($urandom));
    noise_sent += requests_sent - before_cnt;
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ignored while idle
    send_req(eecs_pkg::REQ_NEXT, 16'h0000, 8'h00);
    send_req(eecs_pkg::REQ_FINISH, 16'hFFFF, 8'hFF);
    send_req(eecs_pkg::REQ_REPLY, 16'h0000, 8'h00);
    send_req(REQ_SPARE6, 16'hFFFF, 8'hFF);
    send_req(REQ_SPARE7, 16'h0000, 8'h00);
    // write across the top of the address space, busy status, page restart
    send_req(eecs_pkg::REQ_WRITE, 16'hFFFE, 8'h00);
    send_req(eecs_pkg::REQ_NEXT, 16'h0000, 8'h11);
    send_req(eecs_pkg::REQ_REPLY, 16'h0000, 8'h01);
    send_req(eecs_pkg::REQ_REPLY, 16'hFFFF, 8'hFE);
    send_req(eecs_pkg::REQ_READ, 16'h0000, 8'h00);
    send_req(eecs_pkg::REQ_REPLY, 16'h0000, 8'h00);
    send_req(eecs_pkg::REQ_NEXT, 16'h0000, 8'hAA);
    send_req(eecs_pkg::REQ_NEXT, 16'h0000, 8'h55);
    send_req(eecs_pkg::REQ_NEXT, 16'h0000, 8'h3C);
    send_req(eecs_pkg::REQ_FINISH, 16'h0000, 8'h00);
    send_req(eecs_pkg::REQ_REPLY, 16'h0000, 8'h00);
    send_req(eecs_pkg::REQ_FINISH, 16'h0000, 8'h00);
    // erase, then a read at the last address
    send_req(eecs_pkg::REQ_ERASE, 16'hFFFF, 8'hFF);
    send_req(eecs_pkg::REQ_REPLY, 16'h0000, 8'h00);
    send_req(eecs_pkg::REQ_READ, 16'hFFFF, 8'h00);
    send_req(eecs_pkg::REQ_REPLY, 16'h0000, 8'h00);
    send_req(eecs_pkg::REQ_NEXT, 16'h0000, 8'h00);
    send_req(eecs_pkg::REQ_REPLY, 16'h0000, 8'hFF);
    send_req(eecs_pkg::REQ_FINISH, 16'h0000, 8'h00);
    drain_actions();

    useful_goal = requests_sent + RANDOM_ITEMS;
    while (requests_sent - noise_sent < useful_goal) begin
      quiet = (requests_sent - noise_sent < useful_goal - RANDOM_ITEMS + QUIET_ITEMS);
      case ($urandom_range(9))
        0, 1, 2, 8: write_burst();
        3, 4, 5:    read_burst();
        6: begin
          send_req(eecs_pkg::REQ_ERASE, 16'($urandom), 8'($urandom));
          answer_status();
        end
        7: noise_burst();
        default: begin
          drain_actions();
          read_burst();
        end
      endcase
    end
    quiet = 1'b0;

    drain_actions();
    repeat (20) @(negedge clk);
    $display("covered %0d requests (%0d random codes and recoveries), %0d actions compared",
             requests_sent, noise_sent, actions_checked);
    $display("reads, writes with %0d page restarts, erases, busy status and ignored requests",
             page_restarts);
    if (fail_count == 0 && expected_left == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
